### design/tccw_pkg.sv
package tccw_pkg;

    // Control bytes recognized by the cursor logic, and CH_ZERO, the base of the digit characters
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam int TAB_STEP    = 4;
    localparam int COL_W       = 7;   // cursor column, up to 128 columns
    localparam int ROW_W       = 5;   // cursor row, up to 32 rows
    localparam int IDX_W       = 11;  // cell index on the output
    localparam int LIN_W       = COL_W + ROW_W + 1;
    localparam int STACK_DEPTH = 32;  // digits of a 32-bit number in base 2
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_BITS    = 8;   // dividend bits retired per cycle

    // Register indexes on the config port
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic REG_BG_COLOR   = 1'b1;

    // One character for the cursor engine
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_op;

endpackage

### design/tccw_if.sv
interface tccw_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  char_code;
    logic [31:0] number;
    logic [3:0]  radix;

    modport source (output valid, req_type, char_code, number, radix, input ready);
    modport sink   (input valid, req_type, char_code, number, radix, output ready);
endinterface

interface tccw_out_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [10:0] cell_index;
    logic [15:0] cell_value;
    logic        last;

    modport source (output valid, write_enable, cell_index, cell_value, last, input ready);
    modport sink   (input valid, write_enable, cell_index, cell_value, last, output ready);
endinterface

### design/text_console_cursor_writer.sv
// Character item: written into the queue at its accept edge, then taken by the cursor stage,
// which registers the result; characters can go one per cycle while the output is not stalled.
// Number item of D digits: each digit takes one full pass of the radix divider (8 bits
// per cycle), then one digit result per cycle while the queue has room; the front takes
// the next item after its last digit. A new item is accepted while earlier results
// still drain through queue and output. Reset (i_rst_n low, synchronous): cursor to
// row 0 column 0, queue and output empty, text color 7, background color 0.
module text_console_cursor_writer import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tccw_in_if.sink     i_req,
    tccw_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Color registers
    logic [3:0] r_text_color;
    logic [3:0] r_bg_color;
    logic       w_cfg_wr;

    // Front to queue, queue to back
    logic       w_f_valid;
    t_op        w_f_op;
    logic       w_f_ready;
    logic       w_b_valid;
    t_op        w_b_op;
    logic       w_b_ready;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Registers decoded by word address bit only; one per 32-bit word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= 4'd7;
            r_bg_color   <= 4'd0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_TEXT_COLOR: r_text_color <= pwdata[3:0];
                REG_BG_COLOR:   r_bg_color   <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEXT_COLOR: prdata = {28'd0, r_text_color};
            REG_BG_COLOR:   prdata = {28'd0, r_bg_color};
            default:        prdata = '0;
        endcase
    end

    // Front: takes items, splits numbers into digits
    tccw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_op_valid (w_f_valid),
        .o_op       (w_f_op),
        .i_op_ready (w_f_ready)
    );

    // Two-entry queue decouples digit generation from cursor updates
    tccw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .i_push_op    (w_f_op),
        .o_push_ready (w_f_ready),
        .o_pop_valid  (w_b_valid),
        .o_pop_op     (w_b_op),
        .i_pop_ready  (w_b_ready)
    );

    // Back: cursor tracking, cell address, registered result
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_attr     ({r_bg_color, r_text_color}),
        .i_op_valid (w_b_valid),
        .i_op       (w_b_op),
        .o_op_ready (w_b_ready),
        .o_res      (o_res)
    );

endmodule

### design/tccw_front.sv
module tccw_front import tccw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tccw_in_if.sink   i_req,
    output logic      o_op_valid,
    output t_op       o_op,
    input  logic      i_op_ready
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} t_state;

    t_state           r_state;
    logic [31:0]      r_work;
    logic [3:0]       r_rem;
    logic [3:0]       r_base;
    logic [1:0]       r_step;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]       r_stack [STACK_DEPTH];

    logic             w_acc;
    logic [3:0]       w_base;
    logic [3:0]       w_digit;
    logic [31:0]      w_quot;
    logic             w_push;
    logic             w_pop;

    assign i_req.ready = (r_state == ST_IDLE) && i_op_ready;
    assign w_acc       = i_req.valid && i_req.ready;

    // clamp radix to 2..10
    always_comb begin
        if (i_req.radix < 4'd2) begin
            w_base = 4'd2;
        end else if (i_req.radix > 4'd10) begin
            w_base = 4'd10;
        end else begin
            w_base = i_req.radix;
        end
    end

    // restoring long division, DIV_BITS dividend bits per cycle
    always_comb begin
        logic [4:0]          v_t;
        logic [3:0]          v_rem;
        logic [DIV_BITS-1:0] v_q;
        v_rem = r_rem;
        v_q   = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            v_t = {v_rem, r_work[31-i]};
            if (v_t >= {1'b0, r_base}) begin
                v_t = v_t - {1'b0, r_base};
                v_q[DIV_BITS-1-i] = 1'b1;
            end
            v_rem = v_t[3:0];
        end
        w_digit = v_rem;
        w_quot  = {r_work[31-DIV_BITS:0], v_q};
    end

    assign w_push = (r_state == ST_DIV) && (r_step == 2'd3);
    assign w_pop  = (r_state == ST_EMIT) && i_op_ready;

    assign o_op_valid = (w_acc && !i_req.req_type) || (r_state == ST_EMIT);
    assign o_op.ch    = (r_state == ST_EMIT) ? (CH_ZERO + {4'd0, r_stack[0]}) : i_req.char_code;
    assign o_op.last  = (r_state == ST_EMIT) ? (r_cnt == CNT_W'(1)) : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_req.req_type) begin
                        r_work  <= i_req.number;
                        r_rem   <= '0;
                        r_base  <= w_base;
                        r_step  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_work <= w_quot;
                    r_rem  <= w_digit;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_rem <= '0;
                        r_cnt <= r_cnt + CNT_W'(1);
                        if (w_quot == '0 || r_cnt == CNT_W'(STACK_DEPTH - 1)) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (i_op_ready) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // digit stack: least significant pushed first, top at entry 0
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[0] <= w_digit;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (w_pop) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("digit count overflow");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("emitting from empty digit stack");

endmodule

### design/tccw_queue.sv
module tccw_queue import tccw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_op  i_push_op,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_op  o_pop_op,
    input  logic i_pop_ready
);

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count overflow");

endmodule

### design/tccw_back.sv
module tccw_back import tccw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_attr,
    input  logic       i_op_valid,
    input  t_op        i_op,
    output logic       o_op_ready,
    tccw_out_if.source o_res
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_ovalid;
    logic             r_we;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_val;
    logic             r_last;

    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic             n_we;
    logic [IDX_W-1:0] n_idx;
    logic [15:0]      n_val;
    logic             w_take;
    logic [LIN_W-1:0] w_lin;

    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] row);
        logic [ROW_W:0] v_sum;
        v_sum = {1'b0, row} + (ROW_W+1)'(1);
        next_row = (v_sum >= (ROW_W+1)'(ROWS)) ? '0 : v_sum[ROW_W-1:0];
    endfunction

    assign o_op_ready = !r_ovalid || o_res.ready;
    assign w_take     = i_op_valid && o_op_ready;
    assign w_lin      = LIN_W'(r_row) * LIN_W'(COLUMNS) + LIN_W'(r_col);

    always_comb begin
        logic [COL_W:0]   v_col;
        logic [ROW_W-1:0] v_row;
        v_col = {1'b0, r_col};
        v_row = r_row;
        n_we  = 1'b0;
        n_idx = '0;
        n_val = '0;
        case (i_op.ch)
            CH_CR: begin
                v_col = '0;
            end
            CH_LF: begin
                v_col = '0;
                v_row = next_row(r_row);
            end
            CH_TAB: begin
                v_col = v_col + (COL_W+1)'(TAB_STEP);
            end
            CH_VT: begin
                v_row = next_row(r_row);
            end
            CH_BEL: begin
            end
            default: begin
                n_we  = 1'b1;
                n_idx = w_lin[IDX_W-1:0];
                n_val = {i_attr, i_op.ch};
                v_col = v_col + (COL_W+1)'(1);
            end
        endcase
        // wrap at right edge
        if (v_col >= (COL_W+1)'(COLUMNS)) begin
            v_col = '0;
            v_row = next_row(v_row);
        end
        n_col = v_col[COL_W-1:0];
        n_row = v_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_take) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_ovalid <= 1'b1;
                r_we     <= n_we;
                r_idx    <= n_idx;
                r_val    <= n_val;
                r_last   <= i_op.last;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.write_enable = r_we;
    assign o_res.cell_index   = r_idx;
    assign o_res.cell_value   = r_val;
    assign o_res.last         = r_last;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (COL_W+1)'(r_col) < (COL_W+1)'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ROW_W+1)'(r_row) < (ROW_W+1)'(ROWS))
        else $error("cursor row out of range");

endmodule

### bench/tb_text_console_cursor_writer.sv
`timescale 1ns / 1ps

module tb_text_console_cursor_writer;
    import tccw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    // req_type codes
    localparam bit REQ_CHAR   = 1'b0;
    localparam bit REQ_NUMBER = 1'b1;

    // Register byte addresses on the config port
    localparam logic [2:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
    localparam logic [2:0] ADDR_BG_COLOR   = {REG_BG_COLOR, 2'b00};

    localparam int DRAIN_CYCLES = 10;  // settle time once nothing is outstanding
    localparam int FLOOD_AFTER  = 150; // items taken before the long output hold-off
    localparam int FLOOD_CYCLES = 300;

    typedef struct packed {
        bit        req_type;
        bit [7:0]  char_code;
        bit [31:0] number;
        bit [3:0]  radix;
    } req_t;

    typedef struct packed {
        bit        write_enable;
        bit [10:0] cell_index;
        bit [15:0] cell_value;
        bit        last;
    } cell_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    tccw_in_if  req_if ();
    tccw_out_if res_if ();

    text_console_cursor_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Cursor/screen predictor: its own copy of cursor and colors
    // ------------------------------------------------------------------
    int       cur_col  = 0;
    int       cur_row  = 0;
    bit [3:0] fg_color = 4'd7;
    bit [3:0] bg_color = 4'd0;

    req_t  pending_reqs[$];    // items waiting for the driver
    cell_t expected_cells[$];  // predicted cell writes, oldest first
    int    errors = 0;

    function automatic void advance_row();
        cur_row++;
        if (cur_row >= ROWS) begin
            cur_row = 0;
        end
    endfunction

    // One character through the cursor logic; control bytes give a null write
    function automatic cell_t place_char(bit [7:0] ch, bit is_last);
        cell_t c;
        c      = '0;
        c.last = is_last;
        case (ch)
            CH_CR: begin
                cur_col = 0;
            end
            CH_LF: begin
                cur_col = 0;
                advance_row();
            end
            CH_TAB: begin
                cur_col += TAB_STEP;
            end
            CH_VT: begin
                advance_row();
            end
            CH_BEL: begin
            end
            default: begin
                c.write_enable = 1'b1;
                c.cell_index   = 11'(cur_row * COLUMNS + cur_col);
                c.cell_value   = {bg_color, fg_color, ch};
                cur_col++;
            end
        endcase
        // right-edge wrap also catches TAB running past the edge
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            advance_row();
        end
        return c;
    endfunction

    // Expected cell writes for one accepted item
    function automatic void console_predict(req_t r);
        bit [3:0]  digits[32];
        bit [31:0] num;
        bit [31:0] base;
        int        n;
        if (r.req_type == REQ_CHAR) begin
            expected_cells.push_back(place_char(r.char_code, 1'b1));
        end else begin
            num  = r.number;
            base = r.radix;
            if (base < 2) base = 2;
            if (base > 10) base = 10;
            n = 0;
            // least significant digit first, printed back most significant first
            do begin
                digits[n] = 4'(num % base);
                num       = num / base;
                n++;
            end while (num != 0 && n < 32);
            while (n > 0) begin
                n--;
                expected_cells.push_back(place_char(8'(CH_ZERO + digits[n]), n == 0));
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_char(bit [7:0] ch);
        req_t r;
        r.req_type  = REQ_CHAR;
        r.char_code = ch;
        r.number    = $urandom;               // unused field, keep it noisy
        r.radix     = 4'($urandom_range(0, 15));
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_number(bit [31:0] num, bit [3:0] radix);
        req_t r;
        r.req_type  = REQ_NUMBER;
        r.char_code = 8'($urandom_range(0, 255));
        r.number    = num;
        r.radix     = radix;
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_random(int count);
        bit [7:0]  ctrl_chars[5];
        bit [31:0] num;
        int        p;
        ctrl_chars = '{CH_CR, CH_LF, CH_TAB, CH_VT, CH_BEL};
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, 99);
            if (p < 45) begin
                // mostly short numbers, some full width, a few zeros
                num = $urandom;
                p   = $urandom_range(0, 9);
                if (p == 0) begin
                    num = 0;
                end else if (p < 6) begin
                    num = num >> $urandom_range(8, 31);
                end
                queue_number(num, 4'($urandom_range(0, 15)));
            end else if (p < 70) begin
                queue_char(ctrl_chars[$urandom_range(0, 4)]);
            end else begin
                queue_char(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Gap length: mostly none, some short, a few long; none while calm
    function automatic int idle_len(bit calm);
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: falling edge, one item per handshake
    // ------------------------------------------------------------------
    bit   req_taken = 1'b0;   // item accepted at the last rising edge
    int   reqs_taken = 0;
    int   send_wait  = 0;
    bit   send_calm  = 1'b0;
    req_t next_req;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (req_taken) begin
                send_wait = idle_len(send_calm);
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            end
            if (send_wait > 0) begin
                send_wait--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                req_if.valid     <= 1'b1;
                req_if.req_type  <= next_req.req_type;
                req_if.char_code <= next_req.char_code;
                req_if.number    <= next_req.number;
                req_if.radix     <= next_req.radix;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random stalls plus one long hold-off so the block
    // backs up and has to stall its input
    // ------------------------------------------------------------------
    int recv_wait  = 0;
    bit recv_calm  = 1'b0;
    bit flood_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (!flood_done && reqs_taken >= FLOOD_AFTER) begin
            flood_done = 1'b1;
            recv_wait  = FLOOD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            res_if.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
            recv_wait = idle_len(recv_calm);
            res_if.ready <= (recv_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge; predict on input accept, check on output accept
    // ------------------------------------------------------------------
    cell_t want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                reqs_taken++;
                console_predict({req_if.req_type, req_if.char_code,
                                 req_if.number, req_if.radix});
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_cells.size() == 0) begin
                    $error("unexpected result: cell_index %0d cell_value %0h",
                           res_if.cell_index, res_if.cell_value);
                    errors++;
                end else begin
                    want = expected_cells.pop_front();
                    if (res_if.write_enable !== want.write_enable) begin
                        $error("write_enable: expected %0d, got %0d",
                               want.write_enable, res_if.write_enable);
                        errors++;
                    end
                    if (res_if.cell_index !== want.cell_index) begin
                        $error("cell_index: expected %0d, got %0d",
                               want.cell_index, res_if.cell_index);
                        errors++;
                    end
                    if (res_if.cell_value !== want.cell_value) begin
                        $error("cell_value: expected %0h, got %0h",
                               want.cell_value, res_if.cell_value);
                        errors++;
                    end
                    if (res_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, res_if.last);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Config port write: setup then access; predictor follows the register
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TEXT_COLOR) begin
            fg_color = data[3:0];
        end else begin
            bg_color = data[3:0];
        end
    endtask

    // Checked at rising edges: driver updates have settled, and a high valid
    // covers an item being accepted at this very edge
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || expected_cells.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    bit [3:0] fg_set[4];
    bit [3:0] bg_set[4];

    initial begin
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_CHAR;
        req_if.char_code = '0;
        req_if.number    = '0;
        req_if.radix     = '0;
        res_if.ready     = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under reset colors: field extremes, every control
        // byte and its neighbors, radix clamping, zero, widest numbers
        queue_char("H");
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(CH_CR);
        queue_char(CH_LF);
        queue_char(CH_TAB);
        queue_char(CH_VT);
        queue_char(CH_BEL);
        queue_char(8'h06);
        queue_char(8'h08);
        queue_char(8'h0C);
        queue_char(8'h0E);
        queue_number(32'd0, 4'd10);
        queue_number(32'hFFFF_FFFF, 4'd10);
        queue_number(32'd12345, 4'd0);     // clamps to binary
        queue_number(32'd12345, 4'd1);
        queue_number(32'd255, 4'd15);      // clamps to decimal
        queue_number(32'd255, 4'd11);
        queue_number(32'd8, 4'd8);
        // line up the cursor at column 76 and TAB across the right edge
        queue_char(CH_CR);
        queue_number(32'hFFFF_FFFF, 4'd2);
        queue_number(32'hFFFF_FFFF, 4'd2);
        queue_number(32'h0000_0FFF, 4'd2);
        queue_char(CH_TAB);
        queue_char("x");
        wait_drained();

        // Random phases over several color settings, extremes included
        fg_set = '{4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'd12};
        bg_set = '{4'd15, 4'd0, 4'($urandom_range(1, 14)), 4'd5};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(ADDR_TEXT_COLOR, 32'(fg_set[ph]));
            write_reg(ADDR_BG_COLOR, 32'(bg_set[ph]));
            queue_random(110);
            wait_drained();
        end

        if (errors == 0 && expected_cells.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
